// ----- rtl/rrp_pkg.sv -----
// Package for the RESP request parser: widths, phase codes, result kinds, error codes.
// No dependencies.
`default_nettype none
package rrp_pkg;
    localparam int MaxElements = 3;
    localparam int MaxMessageBytes = 65535;
    localparam logic [15:0] OFF_CAP = 16'((MaxMessageBytes > 65535) ? 65535 : MaxMessageBytes);
    localparam logic [16:0] LEN_CAP = 17'((MaxMessageBytes > 131071) ? 131071 : MaxMessageBytes);

    localparam logic [3:0] PH_ARRAY_MARK = 4'd0;
    localparam logic [3:0] PH_COUNT      = 4'd1;
    localparam logic [3:0] PH_COUNT_LF   = 4'd2;
    localparam logic [3:0] PH_ELEM_MARK  = 4'd3;
    localparam logic [3:0] PH_SIMPLE     = 4'd4;
    localparam logic [3:0] PH_SIMPLE_LF  = 4'd5;
    localparam logic [3:0] PH_BULK_LEN   = 4'd6;
    localparam logic [3:0] PH_BULK_LF    = 4'd7;
    localparam logic [3:0] PH_BULK_DATA  = 4'd8;
    localparam logic [3:0] PH_BULK_TAIL1 = 4'd9;
    localparam logic [3:0] PH_BULK_TAIL2 = 4'd10;
    localparam logic [3:0] PH_DONE       = 4'd11;
    localparam logic [3:0] PH_ERROR      = 4'd12;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_LEAD      = 3'd0;
    localparam logic [2:0] ERR_COUNT     = 3'd1;
    localparam logic [2:0] ERR_DIGIT     = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int QueueDepth = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  element_index;
        logic [7:0]  payload_byte;
        logic        request_done;
        logic [15:0] end_offset;
        logic [2:0]  error_code;
    } out_word_t;
endpackage
`default_nettype wire

// ----- rtl/rrp_if.sv -----
// Valid/ready channel interfaces for the parser's input and result words.
// No dependencies.
`default_nettype none
interface rrp_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rrp_out_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic [1:0] element_index;
    logic [7:0] payload_byte;
    logic request_done;
    logic [15:0] end_offset;
    logic [2:0] error_code;
    modport source (output valid, output kind, output element_index, output payload_byte,
                    output request_done, output end_offset, output error_code, input ready);
    modport sink (input valid, input kind, input element_index, input payload_byte,
                  input request_done, input end_offset, input error_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/resp_request_parser_top.sv -----
// A result word enters the result queue the cycle after its input word is accepted.
// Throughput: one input word per cycle unless the result queue is full and unread.
// The input stalls only when the two-entry result queue is full and not being read.
// Reset (rst_n low, asynchronous) clears parser state and the queue; max_elements returns to 3.
// Depends on rrp_pkg, rrp_if, rrp_front, rrp_queue.
`default_nettype none
module resp_request_parser_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    rrp_in_if.sink          in_ch,
    rrp_out_if.source       out_ch
);
    logic [1:0]         max_elements_reg;
    logic               full, empty, acc, res_valid;
    rrp_pkg::in_word_t  in_word;
    rrp_pkg::out_word_t res_word, q_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_elements_reg <= 2'd3;
        end
        else if (cfg_we)
        begin
            max_elements_reg <= cfg_wdata;
        end
    end

    assign in_ch.ready = !full || out_ch.ready;
    assign acc = in_ch.valid && in_ch.ready;
    assign in_word.data_byte = in_ch.data_byte;
    assign in_word.last_byte = in_ch.last_byte;

    rrp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .max_elements (max_elements_reg),
        .in_valid     (acc),
        .in_word      (in_word),
        .res_valid    (res_valid),
        .res_word     (res_word)
    );

    rrp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_word (res_word),
        .full    (full),
        .empty   (empty),
        .rd_en   (out_ch.valid && out_ch.ready),
        .rd_word (q_word)
    );

    assign out_ch.valid         = !empty;
    assign out_ch.kind          = q_word.kind;
    assign out_ch.element_index = q_word.element_index;
    assign out_ch.payload_byte  = q_word.payload_byte;
    assign out_ch.request_done  = q_word.request_done;
    assign out_ch.end_offset    = q_word.end_offset;
    assign out_ch.error_code    = q_word.error_code;
endmodule
`default_nettype wire

// ----- rtl/rrp_front.sv -----
// Front end: byte parser state machine, one input word per cycle while in_valid is high; emits result words.
// Depends on rrp_pkg.
`default_nettype none
module rrp_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       max_elements,
    input  wire logic             in_valid,
    input  wire rrp_pkg::in_word_t in_word,
    output logic                  res_valid,
    output rrp_pkg::out_word_t    res_word
);
    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  left_reg, left_next;
    logic [1:0]  elem_reg, elem_next;
    logic [16:0] acc_reg, acc_next;
    logic [15:0] off_reg, off_next;
    logic [16:0] rem_reg, rem_next;

    logic [7:0]  b;
    logic        digit;
    logic [1:0]  limit;
    logic [15:0] off;
    logic        errored;
    logic [20:0] acc_x10;
    logic [2:0]  cnt_x10;
    logic [16:0] rem_dec;
    logic [1:0]  elem_out;

    always_comb
    begin
        b       = in_word.data_byte;
        digit   = (b >= rrp_pkg::CH_ZERO) && (b <= rrp_pkg::CH_NINE);
        limit   = (max_elements < 2'(rrp_pkg::MaxElements)) ? max_elements
                                                           : 2'(rrp_pkg::MaxElements);
        off     = (off_reg < rrp_pkg::OFF_CAP) ? off_reg + 16'd1 : rrp_pkg::OFF_CAP;
        acc_x10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + 21'(b - rrp_pkg::CH_ZERO);
        cnt_x10 = (acc_x10 > 21'd4) ? 3'd4 : acc_x10[2:0];
        rem_dec = (rem_reg != 17'd0) ? rem_reg - 17'd1 : 17'd0;

        phase_next = phase_reg;
        left_next  = left_reg;
        elem_next  = elem_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        errored    = 1'b0;
        res_valid  = 1'b0;
        res_word   = '0;
        elem_out   = elem_reg;

        case (phase_reg)
            rrp_pkg::PH_ARRAY_MARK:
            begin
                if (b == rrp_pkg::CH_STAR)
                begin
                    acc_next   = '0;
                    phase_next = rrp_pkg::PH_COUNT;
                end
                else
                begin
                    errored = 1'b1;
                    res_word.error_code = rrp_pkg::ERR_LEAD;
                end
            end
            rrp_pkg::PH_COUNT:
            begin
                if (b == rrp_pkg::CH_CR)
                begin
                    if (acc_reg > {15'd0, limit})
                    begin
                        errored = 1'b1;
                        res_word.error_code = rrp_pkg::ERR_COUNT;
                    end
                    else
                    begin
                        phase_next = rrp_pkg::PH_COUNT_LF;
                    end
                end
                else if (!digit)
                begin
                    errored = 1'b1;
                    res_word.error_code = rrp_pkg::ERR_DIGIT;
                end
                else
                begin
                    acc_next = {14'd0, cnt_x10};
                end
            end
            rrp_pkg::PH_COUNT_LF:
            begin
                elem_next = '0;
                elem_out  = '0;
                if (acc_reg == 17'd0)
                begin
                    left_next  = '0;
                    res_valid  = 1'b1;
                    res_word.kind = rrp_pkg::KIND_END;
                    res_word.request_done = 1'b1;
                    res_word.end_offset = off;
                    phase_next = rrp_pkg::PH_DONE;
                end
                else
                begin
                    left_next  = 2'(acc_reg - 17'd1);
                    phase_next = rrp_pkg::PH_ELEM_MARK;
                end
            end
            rrp_pkg::PH_ELEM_MARK:
            begin
                if (b == rrp_pkg::CH_PLUS)
                begin
                    phase_next = rrp_pkg::PH_SIMPLE;
                end
                else if (b == rrp_pkg::CH_DOLLAR)
                begin
                    acc_next   = '0;
                    phase_next = rrp_pkg::PH_BULK_LEN;
                end
                else
                begin
                    errored = 1'b1;
                    res_word.error_code = rrp_pkg::ERR_LEAD;
                end
            end
            rrp_pkg::PH_SIMPLE:
            begin
                if (b == rrp_pkg::CH_CR)
                begin
                    phase_next = rrp_pkg::PH_SIMPLE_LF;
                end
                else
                begin
                    res_valid = 1'b1;
                    res_word.kind = rrp_pkg::KIND_PAYLOAD;
                    res_word.payload_byte = b;
                end
            end
            rrp_pkg::PH_SIMPLE_LF, rrp_pkg::PH_BULK_TAIL2:
            begin
                res_valid = 1'b1;
                res_word.kind = rrp_pkg::KIND_END;
                if (left_reg == 2'd0)
                begin
                    res_word.request_done = 1'b1;
                    res_word.end_offset = off;
                    phase_next = rrp_pkg::PH_DONE;
                end
                else
                begin
                    left_next  = left_reg - 2'd1;
                    elem_next  = elem_reg + 2'd1;
                    phase_next = rrp_pkg::PH_ELEM_MARK;
                end
            end
            rrp_pkg::PH_BULK_LEN:
            begin
                if (b == rrp_pkg::CH_CR)
                begin
                    phase_next = rrp_pkg::PH_BULK_LF;
                end
                else if (!digit)
                begin
                    errored = 1'b1;
                    res_word.error_code = rrp_pkg::ERR_DIGIT;
                end
                else if (acc_x10 > {4'd0, rrp_pkg::LEN_CAP})
                begin
                    errored = 1'b1;
                    res_word.error_code = rrp_pkg::ERR_OVERFLOW;
                end
                else
                begin
                    acc_next = acc_x10[16:0];
                end
            end
            rrp_pkg::PH_BULK_LF:
            begin
                rem_next   = acc_reg;
                phase_next = (acc_reg == 17'd0) ? rrp_pkg::PH_BULK_TAIL1
                                                : rrp_pkg::PH_BULK_DATA;
            end
            rrp_pkg::PH_BULK_DATA:
            begin
                res_valid = 1'b1;
                res_word.kind = rrp_pkg::KIND_PAYLOAD;
                res_word.payload_byte = b;
                rem_next = rem_dec;
                if (rem_dec == 17'd0)
                begin
                    phase_next = rrp_pkg::PH_BULK_TAIL1;
                end
            end
            rrp_pkg::PH_BULK_TAIL1:
            begin
                phase_next = rrp_pkg::PH_BULK_TAIL2;
            end
            rrp_pkg::PH_DONE:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = rrp_pkg::PH_ERROR;
            end
        endcase

        if (errored)
        begin
            phase_next = rrp_pkg::PH_ERROR;
            res_valid  = 1'b1;
            res_word.kind = rrp_pkg::KIND_ERROR;
        end

        off_next = off;

        if (in_word.last_byte)
        begin
            if (!errored && phase_next != rrp_pkg::PH_DONE && phase_next != rrp_pkg::PH_ERROR)
            begin
                res_valid = 1'b1;
                res_word  = '0;
                res_word.kind = rrp_pkg::KIND_ERROR;
                res_word.error_code = rrp_pkg::ERR_TRUNCATED;
                elem_out = elem_next;
            end
            phase_next = rrp_pkg::PH_ARRAY_MARK;
            left_next  = '0;
            elem_next  = '0;
            acc_next   = '0;
            off_next   = '0;
            rem_next   = '0;
        end

        res_word.element_index = elem_out;
        res_valid = res_valid & in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrp_pkg::PH_ARRAY_MARK;
            left_reg  <= '0;
            elem_reg  <= '0;
            acc_reg   <= '0;
            off_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            elem_reg  <= elem_next;
            acc_reg   <= acc_next;
            off_reg   <= off_next;
            rem_reg   <= rem_next;
        end
    end

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= rrp_pkg::PH_ERROR)
        else $error("phase out of range");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_word.last_byte |=> phase_reg == rrp_pkg::PH_ARRAY_MARK && off_reg == 16'd0)
        else $error("last byte did not clear message state");
    a_done_index: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.request_done |-> res_word.kind == rrp_pkg::KIND_END)
        else $error("done on non end word");
endmodule
`default_nettype wire

// ----- rtl/rrp_queue.sv -----
// Two-entry result queue between parser and output port.
// Depends on rrp_pkg.
`default_nettype none
module rrp_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire rrp_pkg::out_word_t wr_word,
    output logic                    full,
    output logic                    empty,
    input  wire logic               rd_en,
    output rrp_pkg::out_word_t      rd_word
);
    rrp_pkg::out_word_t mem [rrp_pkg::QueueDepth];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg == 2'(rrp_pkg::QueueDepth);
    assign empty   = cnt_reg == 2'd0;
    assign rd_word = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= ~wp_reg;
            end
            if (rd_en)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en || rd_en)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !rd_en)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(rrp_pkg::QueueDepth))
        else $error("queue count out of range");
endmodule
`default_nettype wire
